[rtl/core/mah_pkg.sv]
package mah_pkg;

    localparam logic [31:0] NEXT_MASK = 32'hfffe0c00;
    localparam int RECIP_SHIFT = 26;

    typedef struct packed {
        logic [31:0] header_word;
        logic [15:0] adts_tail;
        logic        tail_present;
        logic        check_length;
        logic [31:0] next_header;
        logic        next_present;
    } t_in_word;

    typedef struct packed {
        logic        valid_res;
        logic [1:0]  version;
        logic [1:0]  layer;
        logic [3:0]  flags;
        logic [12:0] bitrate_kbps;
        logic [16:0] sample_rate_hz;
        logic [1:0]  channel_mode;
        logic [2:0]  channel_config;
        logic [12:0] frame_length;
        logic [10:0] samples_per_frame;
    } t_out_word;

    // bitrate in kbit/s, vi: 0 mpeg1 else 1, li: layer minus one
    function automatic logic [8:0] mpeg_kbps(input logic vi, input logic [1:0] li,
                                             input logic [3:0] idx);
        logic [8:0] k;
        k = 9'd0;
        if (!vi && li == 2'd0) begin
            case (idx)
                4'd1: k = 9'd32;   4'd2: k = 9'd64;   4'd3: k = 9'd96;
                4'd4: k = 9'd128;  4'd5: k = 9'd160;  4'd6: k = 9'd192;
                4'd7: k = 9'd224;  4'd8: k = 9'd256;  4'd9: k = 9'd288;
                4'd10: k = 9'd320; 4'd11: k = 9'd352; 4'd12: k = 9'd384;
                4'd13: k = 9'd416; 4'd14: k = 9'd448;
                default: k = 9'd0;
            endcase
        end else if (!vi && li == 2'd1) begin
            case (idx)
                4'd1: k = 9'd32;   4'd2: k = 9'd48;   4'd3: k = 9'd56;
                4'd4: k = 9'd64;   4'd5: k = 9'd80;   4'd6: k = 9'd96;
                4'd7: k = 9'd112;  4'd8: k = 9'd128;  4'd9: k = 9'd160;
                4'd10: k = 9'd192; 4'd11: k = 9'd224; 4'd12: k = 9'd256;
                4'd13: k = 9'd320; 4'd14: k = 9'd384;
                default: k = 9'd0;
            endcase
        end else if (!vi) begin
            case (idx)
                4'd1: k = 9'd32;   4'd2: k = 9'd40;   4'd3: k = 9'd48;
                4'd4: k = 9'd56;   4'd5: k = 9'd64;   4'd6: k = 9'd80;
                4'd7: k = 9'd96;   4'd8: k = 9'd112;  4'd9: k = 9'd128;
                4'd10: k = 9'd160; 4'd11: k = 9'd192; 4'd12: k = 9'd224;
                4'd13: k = 9'd256; 4'd14: k = 9'd320;
                default: k = 9'd0;
            endcase
        end else if (li == 2'd0) begin
            case (idx)
                4'd1: k = 9'd32;   4'd2: k = 9'd48;   4'd3: k = 9'd56;
                4'd4: k = 9'd64;   4'd5: k = 9'd80;   4'd6: k = 9'd96;
                4'd7: k = 9'd112;  4'd8: k = 9'd128;  4'd9: k = 9'd144;
                4'd10: k = 9'd160; 4'd11: k = 9'd176; 4'd12: k = 9'd192;
                4'd13: k = 9'd224; 4'd14: k = 9'd256;
                default: k = 9'd0;
            endcase
        end else begin
            case (idx)
                4'd1: k = 9'd8;    4'd2: k = 9'd16;   4'd3: k = 9'd24;
                4'd4: k = 9'd32;   4'd5: k = 9'd40;   4'd6: k = 9'd48;
                4'd7: k = 9'd56;   4'd8: k = 9'd64;   4'd9: k = 9'd80;
                4'd10: k = 9'd96;  4'd11: k = 9'd112; 4'd12: k = 9'd128;
                4'd13: k = 9'd144; 4'd14: k = 9'd160;
                default: k = 9'd0;
            endcase
        end
        return k;
    endfunction

    function automatic logic [16:0] mpeg_rate(input logic [1:0] ver, input logic [1:0] idx);
        logic [16:0] r;
        case ({ver, idx})
            4'b00_00: r = 17'd44100;
            4'b00_01: r = 17'd48000;
            4'b00_10: r = 17'd32000;
            4'b01_00: r = 17'd22050;
            4'b01_01: r = 17'd24000;
            4'b01_10: r = 17'd16000;
            4'b10_00: r = 17'd11025;
            4'b10_01: r = 17'd12000;
            4'b10_10: r = 17'd8000;
            default:  r = 17'd0;
        endcase
        return r;
    endfunction

    // floor(2^26 / rate)
    function automatic logic [13:0] mpeg_recip(input logic [1:0] ver, input logic [1:0] idx);
        logic [13:0] r;
        case ({ver, idx})
            4'b00_00: r = 14'd1521;
            4'b00_01: r = 14'd1398;
            4'b00_10: r = 14'd2097;
            4'b01_00: r = 14'd3043;
            4'b01_01: r = 14'd2796;
            4'b01_10: r = 14'd4194;
            4'b10_00: r = 14'd6086;
            4'b10_01: r = 14'd5592;
            4'b10_10: r = 14'd8388;
            default:  r = 14'd0;
        endcase
        return r;
    endfunction

    function automatic logic [16:0] adts_rate(input logic [3:0] idx);
        logic [16:0] r;
        case (idx)
            4'd0:  r = 17'd96000;
            4'd1:  r = 17'd88200;
            4'd2:  r = 17'd64000;
            4'd3:  r = 17'd48000;
            4'd4:  r = 17'd44100;
            4'd5:  r = 17'd32000;
            4'd6:  r = 17'd24000;
            4'd7:  r = 17'd22050;
            4'd8:  r = 17'd16000;
            4'd9:  r = 17'd12000;
            4'd10: r = 17'd11025;
            4'd11: r = 17'd8000;
            4'd12: r = 17'd7350;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/mpeg_audio_header_decode.sv]
// channel   valid         stall         payload
// input     i_in_valid    o_in_stall    i_data  (mah_pkg::t_in_word)
// output    o_out_valid   i_out_stall   o_data  (mah_pkg::t_out_word)
//
// five register stages, one word accepted per cycle while o_in_stall is low
// the frame length quotient uses a reciprocal multiply, a back multiply and
// one correction step, each in a stage of its own
// each stage moves on when it is empty or the next one moves, so bubbles fill
// under an output stall; i_rst_n clears the stage valid bits only
module mpeg_audio_header_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mah_pkg::t_in_word  i_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mah_pkg::t_out_word o_data
);
    import mah_pkg::*;

    typedef struct packed {
        logic        ok;
        logic        adts;
        logic [1:0]  ver;
        logic [1:0]  lay;
        logic [3:0]  flg;
        logic [12:0] kbps;
        logic [16:0] rate;
        logic [1:0]  cmode;
        logic [2:0]  ccfg;
        logic [12:0] flen;
        logic [10:0] spf;
        logic [17:0] spf125;
        logic [2:0]  pad;
        logic        chk;
        logic        nxt_ok;
        logic        match;
        logic [13:0] recip;
        logic [30:0] prod;
        logic [12:0] qest;
        logic [30:0] back;
    } t_work;

    logic [3:0]  r_v;
    t_work       r_s1, r_s2, r_s3, r_s4;
    t_work       n_s1, n_s2, n_s3, n_s4;
    logic        r_vo;
    t_out_word   r_out, n_out;
    logic [4:0]  en;

    assign en[4] = !r_vo || !i_out_stall;
    assign en[3] = !r_v[3] || en[4];
    assign en[2] = !r_v[2] || en[3];
    assign en[1] = !r_v[1] || en[2];
    assign en[0] = !r_v[0] || en[1];
    assign o_in_stall = !en[0];

    // decode and table lookup
    always_comb begin
        logic [7:0] b1, b2, b3;
        logic [1:0] vb, lb, li;
        logic       vi;
        b1 = i_data.header_word[23:16];
        b2 = i_data.header_word[15:8];
        b3 = i_data.header_word[7:0];
        vb = b1[4:3];
        lb = b1[2:1];
        li = 2'd0;
        vi = 1'b0;
        n_s1 = '0;
        n_s1.chk = i_data.check_length;
        n_s1.nxt_ok = i_data.next_present;
        n_s1.match = (i_data.header_word & NEXT_MASK) == (i_data.next_header & NEXT_MASK);
        n_s1.ok = i_data.header_word[31:24] == 8'hff && b1[7:5] == 3'b111 && b1 != 8'hff
                  && vb != 2'd1;
        case (vb)
            2'd0:    n_s1.ver = 2'd2;
            2'd2:    n_s1.ver = 2'd1;
            default: n_s1.ver = 2'd0;
        endcase
        n_s1.flg[0] = !b1[0];
        n_s1.lay = 2'd0 - lb;
        if (lb == 2'd0) begin
            n_s1.adts = 1'b1;
            if (vb == 2'd2) begin
                n_s1.ver = 2'd3;
            end else if (vb == 2'd3) begin
                n_s1.ver = 2'd1;
            end else begin
                n_s1.ok = 1'b0;
            end
            n_s1.rate = adts_rate(b2[5:2]);
            n_s1.spf = 11'd1024;
            n_s1.ccfg = {b2[0], b3[7:6]};
            n_s1.cmode = (n_s1.ccfg == 3'd1) ? 2'd3 : 2'd0;
            n_s1.flg[3] = b3[5];
            n_s1.flg[2] = b3[2];
            if (i_data.tail_present) begin
                n_s1.flen = {b3[1:0], i_data.adts_tail[15:8], i_data.adts_tail[7:5]};
            end
        end else begin
            vi = n_s1.ver != 2'd0;
            li = 2'd3 - lb;
            n_s1.kbps = {4'd0, mpeg_kbps(vi, li, b2[7:4])};
            n_s1.rate = mpeg_rate(n_s1.ver, b2[3:2]);
            n_s1.recip = mpeg_recip(n_s1.ver, b2[3:2]);
            if (n_s1.kbps == 13'd0 || n_s1.rate == 17'd0) begin
                n_s1.ok = 1'b0;
            end
            n_s1.cmode = b3[7:6];
            n_s1.flg[3] = b3[2];
            n_s1.flg[2] = b3[3];
            n_s1.flg[1] = b2[1];
            case (li)
                2'd0: begin
                    n_s1.spf = 11'd384;
                    n_s1.spf125 = 18'd48000;
                    n_s1.pad = 3'd4;
                end
                2'd1: begin
                    n_s1.spf = 11'd1152;
                    n_s1.spf125 = 18'd144000;
                    n_s1.pad = 3'd1;
                end
                default: begin
                    n_s1.spf = vi ? 11'd576 : 11'd1152;
                    n_s1.spf125 = vi ? 18'd72000 : 18'd144000;
                    n_s1.pad = 3'd1;
                end
            endcase
        end
    end

    // numerator product
    always_comb begin
        n_s2 = r_s1;
        if (r_s1.adts) begin
            n_s2.prod = {18'd0, r_s1.flen} * {14'd0, r_s1.rate};
        end else begin
            n_s2.prod = r_s1.kbps * r_s1.spf125;
        end
    end

    // reciprocal multiply, adts bitrate rounding
    always_comb begin
        logic [40:0] q;
        logic [30:0] s;
        n_s3 = r_s2;
        q = r_s2.prod[25:0] * {1'b0, r_s2.recip};
        s = r_s2.prod + 31'd512;
        if (r_s2.adts) begin
            n_s3.kbps = s[29:17];
        end else begin
            n_s3.qest = q[RECIP_SHIFT +: 13];
        end
    end

    // back multiply
    always_comb begin
        n_s4 = r_s3;
        n_s4.back = r_s3.qest * r_s3.rate;
    end

    // correction, padding, next header check
    always_comb begin
        logic [30:0] rem;
        logic [12:0] fl;
        rem = r_s4.prod - r_s4.back;
        fl = r_s4.flen;
        if (!r_s4.adts) begin
            fl = r_s4.qest + ((rem >= {14'd0, r_s4.rate}) ? 13'd1 : 13'd0);
            if (r_s4.flg[1]) begin
                fl = fl + {10'd0, r_s4.pad};
            end
        end
        n_out = '0;
        if (r_s4.ok && !(r_s4.chk && (fl == 13'd0 || !r_s4.nxt_ok || !r_s4.match))) begin
            n_out.valid_res = 1'b1;
            n_out.version = r_s4.ver;
            n_out.layer = r_s4.lay;
            n_out.flags = r_s4.flg;
            n_out.bitrate_kbps = r_s4.kbps;
            n_out.sample_rate_hz = r_s4.rate;
            n_out.channel_mode = r_s4.cmode;
            n_out.channel_config = r_s4.ccfg;
            n_out.frame_length = fl;
            n_out.samples_per_frame = r_s4.spf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
            r_vo <= 1'b0;
        end else begin
            if (en[0]) r_v[0] <= i_in_valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
            if (en[3]) r_v[3] <= r_v[2];
            if (en[4]) r_vo <= r_v[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) r_s1 <= n_s1;
        if (en[1]) r_s2 <= n_s2;
        if (en[2]) r_s3 <= n_s3;
        if (en[3]) r_s4 <= n_s4;
        if (en[4]) r_out <= n_out;
    end

    assign o_out_valid = r_vo;
    assign o_data = r_out;

    a_zero_when_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_data.valid_res |-> o_data == '0)
        else $error("rejected header carries nonzero fields");

    a_adts_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_data.valid_res && o_data.layer == 2'd0
        |-> o_data.samples_per_frame == 11'd1024 && o_data.flags[1] == 1'b0)
        else $error("adts result with wrong frame shape");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_v[0] && r_v[1] && r_v[2] && r_v[3] && r_vo && i_out_stall)
        else $error("input stalled with a free stage");

endmodule

[tb/sv/tb_mpeg_audio_header_decode.sv]
`timescale 1ns / 100ps

class header_scoreboard;
    mah_pkg::t_out_word pending[$];
    int mismatches;

    function int unsigned pick(logic [3:0] idx, int unsigned t[16]);
        return t[idx];
    endfunction

    function mah_pkg::t_out_word decode(mah_pkg::t_in_word w);
        mah_pkg::t_out_word r;
        logic [7:0] b0, b1, b2, b3;
        logic [1:0] vb, lb, li;
        logic vi;
        int unsigned kbps, rate, spf, flen;
        logic [63:0] prod;
        bit ok;
        r = '0;
        kbps = 0; rate = 0; spf = 0; flen = 0;
        {b0, b1, b2, b3} = w.header_word;
        ok = !(b0 != 8'hff || b1[7:5] != 3'b111 || b1 == 8'hff);
        vb = b1[4:3];
        lb = b1[2:1];
        if (ok) begin
            case (vb)
                2'd0: r.version = 2'd2;
                2'd2: r.version = 2'd1;
                2'd3: r.version = 2'd0;
                default: ok = 0;
            endcase
            if (ok) begin
                if (lb != 0) r.layer = 2'd3 - lb + 2'd1;
                else if (vb == 2'd2) begin r.version = 2'd3; r.layer = 0; end
                else if (vb == 2'd3) begin r.version = 2'd1; r.layer = 0; end
                else ok = 0;
            end
            if (ok && !b1[0]) r.flags[0] = 1;
        end
        if (ok && r.layer == 0) begin
            case (b2[5:2])
                0: rate = 96000; 1: rate = 88200; 2: rate = 64000; 3: rate = 48000;
                4: rate = 44100; 5: rate = 32000; 6: rate = 24000; 7: rate = 22050;
                8: rate = 16000; 9: rate = 12000; 10: rate = 11025; 11: rate = 8000;
                12: rate = 7350; default: rate = 0;
            endcase
            spf = 1024;
            r.channel_config = {b2[0], b3[7:6]};
            r.channel_mode = (r.channel_config == 3'd1) ? 2'd3 : 2'd0;
            if (b3[5]) r.flags[3] = 1;
            if (b3[2]) r.flags[2] = 1;
            if (w.tail_present) begin
                flen = {b3[1:0], w.adts_tail[15:8], w.adts_tail[7:5]};
                prod = 64'(flen) * rate + 512;
                kbps = 32'(((prod >> 10) * 8) / 1024);
            end
        end else if (ok) begin
            vi = (r.version != 0);
            li = r.layer - 2'd1;
            case ({vi, li})
                3'b0_00: kbps = pick(b2[7:4], '{0,32,64,96,128,160,192,224,256,288,320,352,
                                               384,416,448,0});
                3'b0_01: kbps = pick(b2[7:4], '{0,32,48,56,64,80,96,112,128,160,192,224,256,
                                               320,384,0});
                3'b0_10: kbps = pick(b2[7:4], '{0,32,40,48,56,64,80,96,112,128,160,192,224,
                                               256,320,0});
                3'b1_00: kbps = pick(b2[7:4], '{0,32,48,56,64,80,96,112,128,144,160,176,192,
                                               224,256,0});
                default: kbps = pick(b2[7:4], '{0,8,16,24,32,40,48,56,64,80,96,112,128,144,
                                               160,0});
            endcase
            if (kbps == 0) ok = 0;
            if (ok) begin
                case ({r.version, b2[3:2]})
                    4'b0000: rate = 44100; 4'b0001: rate = 48000; 4'b0010: rate = 32000;
                    4'b0100: rate = 22050; 4'b0101: rate = 24000; 4'b0110: rate = 16000;
                    4'b1000: rate = 11025; 4'b1001: rate = 12000; 4'b1010: rate = 8000;
                    default: rate = 0;
                endcase
                if (rate == 0) ok = 0;
            end
            if (ok) begin
                r.channel_mode = b3[7:6];
                if (b3[2]) r.flags[3] = 1;
                if (b3[3]) r.flags[2] = 1;
                if (b2[1]) r.flags[1] = 1;
                spf = (li == 0) ? 384 : (li == 1 || !vi) ? 1152 : 576;
                flen = (spf * kbps * 125) / rate;
                if (r.flags[1]) flen += (li == 0) ? 4 : 1;
            end
        end
        if (ok && w.check_length) begin
            if (flen == 0 || !w.next_present ||
                (w.header_word & mah_pkg::NEXT_MASK) != (w.next_header & mah_pkg::NEXT_MASK))
                ok = 0;
        end
        if (!ok) return '0;
        r.valid_res = 1;
        r.bitrate_kbps = kbps[12:0];
        r.sample_rate_hz = rate[16:0];
        r.frame_length = flen[12:0];
        r.samples_per_frame = spf[10:0];
        return r;
    endfunction

    function void note_header(mah_pkg::t_in_word w);
        pending.push_back(decode(w));
    endfunction

    function void check_result(mah_pkg::t_out_word got);
        mah_pkg::t_out_word exp_r;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", got);
            return;
        end
        exp_r = pending.pop_front();
        if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch exp %p got %p", exp_r, got);
        end
    endfunction
endclass

module tb_mpeg_audio_header_decode;
    logic i_clk = 0, i_rst_n = 0;
    logic i_in_valid = 0, i_out_stall = 0;
    logic o_in_stall, o_out_valid;
    mah_pkg::t_in_word i_data = '0;
    mah_pkg::t_out_word o_data;
    header_scoreboard board = new();
    bit calm = 0;
    int idle_cycles = 0;

    mpeg_audio_header_decode i_dut (.*);

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_result(o_data);
        if (i_rst_n && ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > 2000) begin
            $display("mpeg_audio_header_decode test failed");
            $finish;
        end
    end

    always @(negedge i_clk) i_out_stall <= !calm && ($urandom_range(99) < 7);

    task automatic send_word(mah_pkg::t_in_word w);
        while (!calm && $urandom_range(99) < 7) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_data <= w;
        i_in_valid <= 1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_header(w);
        @(negedge i_clk);
    endtask

    function automatic mah_pkg::t_in_word make_word(bit sane);
        mah_pkg::t_in_word w;
        logic [95:0] raw;
        logic [31:0] m;
        raw = {$urandom, $urandom, $urandom};
        w = raw[82:0];
        if (sane) begin
            w.header_word[31:21] = 11'h7ff;
            if ($urandom_range(3) == 0) w.header_word[20:19] = 2'b11;
            m = $urandom & ~mah_pkg::NEXT_MASK;
            if ($urandom_range(3) != 0)
                w.next_header = (w.header_word & mah_pkg::NEXT_MASK) | m;
        end
        return w;
    endfunction

    initial begin
        mah_pkg::t_in_word w;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        w = '0; send_word(w);
        w = '1; send_word(w);
        for (int i = 0; i < 16; i++) begin
            w = '0;
            w.header_word = {8'hff, 3'b111, i[3:0], 1'b0, 8'hf5, 8'hfc};
            w.adts_tail = 16'hffff; w.tail_present = i[0];
            w.check_length = i[1]; w.next_present = 1;
            w.next_header = w.header_word;
            send_word(w);
        end
        w.header_word = 32'hfff1fc00; w.tail_present = 0; w.check_length = 0;
        send_word(w);
        w.header_word = 32'hfffbe404; w.check_length = 1; w.next_present = 0;
        send_word(w);
        w.header_word = 32'hfffbf064; send_word(w);
        w.header_word = 32'hfff3f2c8; w.check_length = 0; send_word(w);
        w.header_word = 32'hffe0f0ff; send_word(w);
        for (int n = 0; n < 1100; n++) begin
            if (n == 300) calm = 1;
            if (n == 500) calm = 0;
            if (n == 700) begin
                i_in_valid <= 0;
                @(negedge i_clk);
                while (board.pending.size() != 0) @(negedge i_clk);
            end
            send_word(make_word($urandom_range(9) != 0));
        end
        i_in_valid <= 0;
        @(negedge i_clk);
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (board.mismatches == 0)
            $display("mpeg_audio_header_decode test passed");
        else
            $display("mpeg_audio_header_decode test failed");
        $finish;
    end
endmodule

[filelist.f]
rtl/core/mah_pkg.sv
rtl/core/mpeg_audio_header_decode.sv
tb/sv/tb_mpeg_audio_header_decode.sv
